// ===== hdl/evh_pkg.sv =====
// shared types, register codes and constants of the energy voice-activity detector
package evh_pkg;

  // default for the longest counted frame
  localparam int MAX_FRAME_SAMPLES_DEF = 1024;

  // sample and power widths
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int SQ_W     = 31;   // square of a 16-bit magnitude, up to 2**30
  localparam int MEAN_W   = 31;   // mean square, up to 2**30
  localparam int ROOT_W   = 32;   // working width of the square root
  localparam int RMS_W    = 16;
  localparam int RUN_W    = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOUD_NEEDED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_NEEDED = 2'd2;

  localparam logic [15:0]      SPEECH_LEVEL_RST = 16'd900;
  localparam logic [RUN_W-1:0] LOUD_NEEDED_RST  = 8'd3;
  localparam logic [RUN_W-1:0] QUIET_NEEDED_RST = 8'd60;
  localparam logic [RUN_W-1:0] RUN_MAX          = 8'hFF;

  // first root trial bit, 1 << 30
  localparam logic [ROOT_W-1:0] ROOT_TOP_BIT = 32'h4000_0000;

  typedef struct packed {
    logic [15:0]      speech_level;
    logic [RUN_W-1:0] loud_needed;
    logic [RUN_W-1:0] quiet_needed;
  } cfg_t;

  typedef struct packed {
    logic [RMS_W-1:0] rms_level;
    logic             speech;
    logic             changed;
  } result_t;

  // handshake between the front end and the frame queue
  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

// ===== hdl/energy_vad_hysteresis.sv =====
// top level of the energy voice-activity detector with rms level and hysteresis
//
// input words: in_sample (signed 16 bit) with in_frame_end marking the last
//   sample of a frame; a word is taken on a clock edge with in_push high and
//   in_full low
// result words: one per frame, in_frame_end order; out_rms_level, out_speech
//   and out_changed are valid while out_empty is low and leave on out_pop
// configuration: cfg_we writes cfg_wdata into the register picked by
//   cfg_index (speech level, loud frames needed, quiet frames needed); other
//   indexes are ignored; write only while idle
// throughput: one sample every cycle; in_full only rises when a frame end
//   reaches the front of the pipe while the two-word frame queue is full
// result path: a one-bit-a-cycle divider works through the SUM_W-bit frame sum
//   (SUM_W = 30 + clog2(MAX_FRAME_SAMPLES + 1), 41 by default), then the 16
//   steps of the square root in the back end
// the back end takes a new frame from the queue only when idle, after the
//   result of the last one is written
// a stalled receiver keeps the result register full; the back end then waits,
//   the queue fills and finally in_full holds the sender
// reset (rst_n low, synchronous): empty queues, zero sums and run counters,
//   silence, and the registers back at 900, 3 and 60
module energy_vad_hysteresis #(
  parameter int MAX_FRAME_SAMPLES = evh_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample words
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic signed [evh_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                  in_frame_end,
  // frame results
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [evh_pkg::RMS_W-1:0]             out_rms_level,
  output logic                                  out_speech,
  output logic                                  out_changed,
  // register writes
  input  logic                                  cfg_we,
  input  logic [evh_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [evh_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = 30 + CNT_W;
  localparam int Q_W   = SUM_W + CNT_W;

  evh_pkg::cfg_t    cfg_r;
  evh_pkg::qctl_t   qctl;
  evh_pkg::result_t result;

  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [Q_W-1:0]   q_push_data;
  logic [Q_W-1:0]   q_pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speech_level <= evh_pkg::SPEECH_LEVEL_RST;
      cfg_r.loud_needed  <= evh_pkg::LOUD_NEEDED_RST;
      cfg_r.quiet_needed <= evh_pkg::QUIET_NEEDED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        evh_pkg::REG_SPEECH_LEVEL: cfg_r.speech_level <= cfg_wdata;
        evh_pkg::REG_LOUD_NEEDED:  cfg_r.loud_needed  <= cfg_wdata[evh_pkg::RUN_W-1:0];
        evh_pkg::REG_QUIET_NEEDED: cfg_r.quiet_needed <= cfg_wdata[evh_pkg::RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // squaring and frame accumulation
  evh_front #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_sample    (in_sample),
    .in_frame_end (in_frame_end),
    .qctl         (qctl),
    .q_full       (q_full),
    .q_data       (q_push_data)
  );

  // finished frames waiting for the back end
  evh_fifo #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (qctl.push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // mean, root and hysteresis
  evh_back #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .result    (result)
  );

  assign out_rms_level = result.rms_level;
  assign out_speech    = result.speech;
  assign out_changed   = result.changed;

  // a finished frame is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qctl.push |-> !q_full)
    else $error("frame pushed into full queue");

  // the back end only takes a frame that is there
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("frame popped from empty queue");

  // the sender is only held back by a full frame queue
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> qctl.full)
    else $error("input held without a full queue");

  // a waiting result is not lost without a pop
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result dropped without pop");

endmodule

// ===== hdl/evh_fifo.sv =====
// two-word frame queue between the front end and the back end
module evh_fifo #(
  parameter int WIDTH = 52
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;

  logic do_push;
  logic do_pop;

  assign do_push  = push && (fill_r != 2'd2);
  assign do_pop   = pop && (fill_r != 2'd0);
  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/evh_front.sv =====
// front end: squares samples, counts and sums each frame, queues finished frames
module evh_front #(
  parameter int MAX_FRAME_SAMPLES = evh_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [evh_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_frame_end,
  output evh_pkg::qctl_t                      qctl,
  input  logic                                q_full,
  output logic [30+2*$clog2(MAX_FRAME_SAMPLES+1)-1:0] q_data
);

  localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W = 30 + CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_SAMPLES);

  logic [CNT_W-1:0]            cnt_r;
  logic                        s1_valid_r;
  logic                        s1_last_r;
  logic [evh_pkg::SQ_W-1:0]    sq_r;
  logic [CNT_W-1:0]            s1_cnt_r;
  logic [SUM_W-1:0]            sum_r;

  logic                        accept;
  logic                        counted;
  logic [CNT_W-1:0]            cnt_nxt;
  logic [evh_pkg::MAG_W-1:0]   mag;
  logic [2*evh_pkg::MAG_W-1:0] sq_full;
  logic                        s1_blocked;
  logic                        s1_advance;
  logic [SUM_W-1:0]            total;

  assign s1_blocked = s1_valid_r && s1_last_r && q_full;
  assign s1_advance = s1_valid_r && !s1_blocked;
  assign in_full    = s1_blocked;
  assign accept     = in_push && !in_full;

  // samples past the frame limit are dropped from sum and count
  assign counted = (cnt_r < CNT_MAX);
  assign cnt_nxt = counted ? (cnt_r + CNT_W'(1)) : cnt_r;

  // magnitude of the two's complement sample, 32768 included
  assign mag     = in_sample[evh_pkg::SAMPLE_W-1] ? (~in_sample + 16'd1) : in_sample;
  assign sq_full = mag * mag;

  assign total = sum_r + SUM_W'(sq_r);

  assign qctl.push = s1_advance && s1_last_r;
  assign qctl.full = q_full;
  assign q_data    = {total, s1_cnt_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r      <= counted ? sq_full[evh_pkg::SQ_W-1:0] : '0;
      s1_last_r <= in_frame_end;
      s1_cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      if (accept) begin
        cnt_r <= in_frame_end ? '0 : cnt_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance) begin
        sum_r <= s1_last_r ? '0 : total;
      end
    end
  end

endmodule

// ===== hdl/evh_back.sv =====
// back end: mean by restoring division, bit-pair square root, hysteresis, result register
module evh_back #(
  parameter int MAX_FRAME_SAMPLES = evh_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  evh_pkg::cfg_t          cfg,
  input  logic                   q_empty,
  input  logic [30+2*$clog2(MAX_FRAME_SAMPLES+1)-1:0] q_data,
  output logic                   q_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output evh_pkg::result_t       result
);

  localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W  = 30 + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_HYST = 2'd3;

  logic [1:0]                   state_r;
  logic [STEP_W-1:0]            step_r;
  logic [SUM_W-1:0]             quo_r;
  logic [CNT_W-1:0]             rem_r;
  logic [CNT_W-1:0]             div_r;
  logic [evh_pkg::ROOT_W-1:0]   x_r;
  logic [evh_pkg::ROOT_W-1:0]   y_r;
  logic [evh_pkg::ROOT_W-1:0]   b_r;
  logic [evh_pkg::RUN_W-1:0]    loud_run_r;
  logic [evh_pkg::RUN_W-1:0]    quiet_run_r;
  logic                         speech_r;
  logic                         out_valid_r;
  evh_pkg::result_t             result_r;

  logic [CNT_W:0]               trial;
  logic                         ge;
  logic [CNT_W-1:0]             rem_nxt;
  logic [SUM_W-1:0]             quo_nxt;
  logic [evh_pkg::ROOT_W-1:0]   t;
  logic                         fits;
  logic                         loud;
  logic [evh_pkg::RUN_W-1:0]    loud_inc;
  logic [evh_pkg::RUN_W-1:0]    quiet_inc;
  logic                         speech_nxt;
  logic                         can_write;

  // one quotient bit a cycle
  assign trial   = {rem_r, quo_r[SUM_W-1]};
  assign ge      = (trial >= {1'b0, div_r});
  assign rem_nxt = ge ? CNT_W'(trial - {1'b0, div_r}) : trial[CNT_W-1:0];
  assign quo_nxt = {quo_r[SUM_W-2:0], ge};

  // one root bit a cycle
  assign t    = y_r + b_r;
  assign fits = (x_r >= t);

  assign loud      = (y_r[evh_pkg::RMS_W-1:0] >= cfg.speech_level);
  assign loud_inc  = (loud_run_r == evh_pkg::RUN_MAX) ? loud_run_r
                                                      : loud_run_r + 8'd1;
  assign quiet_inc = (quiet_run_r == evh_pkg::RUN_MAX) ? quiet_run_r
                                                       : quiet_run_r + 8'd1;
  always_comb begin
    speech_nxt = speech_r;
    if (loud) begin
      if (loud_inc >= cfg.loud_needed) begin
        speech_nxt = 1'b1;
      end
    end else begin
      if (quiet_inc >= cfg.quiet_needed) begin
        speech_nxt = 1'b0;
      end
    end
  end

  assign can_write = !out_valid_r || out_pop;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign result    = result_r;

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        quo_r  <= q_data[CNT_W +: SUM_W];
        div_r  <= q_data[CNT_W-1:0];
        rem_r  <= '0;
        step_r <= STEP_W'(SUM_W - 1);
      end
      ST_DIV: begin
        quo_r  <= quo_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r - STEP_W'(1);
        x_r    <= evh_pkg::ROOT_W'(quo_nxt[evh_pkg::MEAN_W-1:0]);
        y_r    <= '0;
        b_r    <= evh_pkg::ROOT_TOP_BIT;
      end
      ST_ROOT: begin
        if (fits) begin
          x_r <= x_r - t;
          y_r <= (y_r >> 1) + b_r;
        end else begin
          y_r <= y_r >> 1;
        end
        b_r <= b_r >> 2;
      end
      default: begin
        if (can_write) begin
          result_r.rms_level <= y_r[evh_pkg::RMS_W-1:0];
          result_r.speech    <= speech_nxt;
          result_r.changed   <= (speech_nxt != speech_r);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loud_run_r  <= '0;
      quiet_run_r <= '0;
      speech_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_HYST) && can_write) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step_r == '0) begin
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (b_r[0]) begin
            state_r <= ST_HYST;
          end
        end
        default: begin
          if (can_write) begin
            speech_r    <= speech_nxt;
            if (loud) begin
              loud_run_r  <= loud_inc;
              quiet_run_r <= '0;
            end else begin
              quiet_run_r <= quiet_inc;
              loud_run_r  <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
